>>> design/bpf_pkg.sv
// bpf_pkg: shared types and constants of the Bezier path flattener.
// Used by bpf_front, bpf_eval, bpf_outq and bezier_path_flattener_core.
`timescale 1ns / 1ps
package bpf_pkg;

  localparam int SEGMENTS_DEF = 32;
  localparam int CW = 32;

  typedef enum logic [1:0] {
    FN_MOVE  = 2'd0,
    FN_LINE  = 2'd1,
    FN_QUAD  = 2'd2,
    FN_CUBIC = 2'd3
  } func_t;

  // classified command: control points and the final pen position
  typedef struct packed {
    func_t                 func;
    logic signed [CW-1:0]  p1x;
    logic signed [CW-1:0]  p1y;
    logic signed [CW-1:0]  p2x;
    logic signed [CW-1:0]  p2y;
    logic signed [CW-1:0]  p3x;
    logic signed [CW-1:0]  p3y;
    logic signed [CW-1:0]  ex;
    logic signed [CW-1:0]  ey;
  } cmd_t;

  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic                  brk;
    logic                  last;
  } vtx_t;

endpackage

>>> design/bpf_front.sv
// bpf_front: accepts path commands, classifies them and holds them in a
// two-word command queue for the evaluator. Depends on bpf_pkg.
`timescale 1ns / 1ps
module bpf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   in_func,
  input  logic signed [bpf_pkg::CW-1:0] in_ax,
  input  logic signed [bpf_pkg::CW-1:0] in_ay,
  input  logic signed [bpf_pkg::CW-1:0] in_bx,
  input  logic signed [bpf_pkg::CW-1:0] in_by,
  input  logic signed [bpf_pkg::CW-1:0] in_cx,
  input  logic signed [bpf_pkg::CW-1:0] in_cy,
  output logic                         cmd_valid,
  output bpf_pkg::cmd_t                cmd,
  input  logic                         cmd_take
);

  bpf_pkg::cmd_t cls;
  bpf_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          wr_en, rd_en;

  always_comb begin
    cls.func = bpf_pkg::func_t'(in_func);
    cls.p1x  = in_ax;
    cls.p1y  = in_ay;
    cls.p2x  = in_bx;
    cls.p2y  = in_by;
    cls.p3x  = '0;
    cls.p3y  = '0;
    cls.ex   = in_ax;
    cls.ey   = in_ay;
    case (cls.func)
      bpf_pkg::FN_QUAD: begin
        cls.ex = in_bx;
        cls.ey = in_by;
      end
      bpf_pkg::FN_CUBIC: begin
        cls.p3x = in_cx;
        cls.p3y = in_cy;
        cls.ex  = in_cx;
        cls.ey  = in_cy;
      end
      default: begin
      end
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

>>> design/bpf_eval.sv
// bpf_eval: keeps the pen and turns commands into vertices; curves go through a
// shared multiply-accumulate and a byte-wise reciprocal rounding divider. Depends on bpf_pkg.
`timescale 1ns / 1ps
module bpf_eval #(
  parameter int SEGMENTS = bpf_pkg::SEGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  bpf_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          vtx_push,
  output bpf_pkg::vtx_t vtx,
  input  logic          oq_full
);

  localparam int IW = $clog2(SEGMENTS + 1);
  localparam int WW = 3 * IW + 2;
  localparam int AW = 56;
  localparam int PW = WW + 33;
  localparam int D2 = SEGMENTS * SEGMENTS;
  localparam int D3 = D2 * SEGMENTS;
  localparam logic [IW-1:0] SEG  = IW'(SEGMENTS);
  localparam logic [AW-1:0] DEN2 = AW'(D2);
  localparam logic [AW-1:0] DEN3 = AW'(D3);
  // divisors 2*D, remainder width, reciprocals and their shifts
  localparam longint M2  = 2 * longint'(D2);
  localparam longint M3  = 2 * longint'(D3);
  localparam int     RB  = $clog2(M3 + 1);
  localparam int     XW  = RB + 8;
  localparam int     CB  = RB + 9;
  localparam int     L2  = $clog2(M2);
  localparam int     L3  = $clog2(M3);
  localparam int     SH2 = 2 * L2 + 8;
  localparam int     SH3 = 2 * L3 + 8;
  localparam longint RC2 = ((longint'(1) << SH2) + M2 - 1) / M2;
  localparam longint RC3 = ((longint'(1) << SH3) + M3 - 1) / M3;
  localparam logic [RB-1:0] MOD2 = RB'(M2);
  localparam logic [RB-1:0] MOD3 = RB'(M3);
  localparam logic [CB-1:0] REC2 = CB'(RC2);
  localparam logic [CB-1:0] REC3 = CB'(RC3);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WGT  = 6'b000010,
    S_MUL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [IW-1:0]                 i_r;
  logic [1:0]                    k_r;
  logic [4:0]                    cnt_r;
  logic                          cubic_r, brk_r, last_r;
  logic signed [bpf_pkg::CW-1:0] cur_x_r, cur_y_r;
  logic signed [bpf_pkg::CW-1:0] px_r [4];
  logic signed [bpf_pkg::CW-1:0] py_r [4];
  logic [WW-1:0]                 w_r [4];
  logic signed [AW-1:0]          prx_r, pry_r, acx_r, acy_r;
  logic [RB-1:0]                 rx_r, ry_r;
  logic [bpf_pkg::CW-1:0]        lx_r, ly_r;
  logic [XW-1:0]                 xx_r, xy_r;
  logic [7:0]                    dx_r, dy_r;
  logic [bpf_pkg::CW-1:0]        qx_r, qy_r;

  logic [IW-1:0]        u;
  logic [WW-1:0]        ie, ue, t_iuu, t_iiu;
  logic [WW-1:0]        w_nxt [4];
  logic signed [PW-1:0] mx, my;
  logic signed [AW-1:0] sx, sy;
  logic [AW-1:0]        dd, nvx, nvy;
  logic [CB-1:0]        rec;
  logic [RB-1:0]        mdv;
  logic [XW-1:0]        xdx, xdy;
  logic [XW+CB-1:0]     pqx, pqy;
  logic [7:0]           dgx, dgy;
  logic                 is_seg;

  // Bernstein weights of vertex i, u = SEGMENTS - i
  always_comb begin
    u     = SEG - i_r;
    ie    = WW'(i_r);
    ue    = WW'(u);
    t_iuu = ie * ue * ue;
    t_iiu = ie * ie * ue;
    if (cubic_r) begin
      w_nxt[0] = ue * ue * ue;
      w_nxt[1] = t_iuu + (t_iuu << 1);
      w_nxt[2] = t_iiu + (t_iiu << 1);
      w_nxt[3] = ie * ie * ie;
    end else begin
      w_nxt[0] = ue * ue;
      w_nxt[1] = (ie * ue) << 1;
      w_nxt[2] = ie * ie;
      w_nxt[3] = '0;
    end
  end

  assign mx     = $signed({1'b0, w_r[k_r]}) * px_r[k_r];
  assign my     = $signed({1'b0, w_r[k_r]}) * py_r[k_r];
  assign sx     = acx_r + prx_r;
  assign sy     = acy_r + pry_r;
  assign dd     = cubic_r ? DEN3 : DEN2;
  assign is_seg = (i_r == SEG);

  // 2*sum + D, offset by 2*D*2^31 so the dividend is never negative
  assign nvx = {sx[AW-2:0], 1'b0} + dd + (dd << 32);
  assign nvy = {sy[AW-2:0], 1'b0} + dd + (dd << 32);

  // one quotient byte: remainder with the next dividend byte, times the reciprocal
  assign rec = cubic_r ? REC3 : REC2;
  assign mdv = cubic_r ? MOD3 : MOD2;
  assign xdx = {rx_r, lx_r[bpf_pkg::CW-1:bpf_pkg::CW-8]};
  assign xdy = {ry_r, ly_r[bpf_pkg::CW-1:bpf_pkg::CW-8]};
  assign pqx = xdx * rec;
  assign pqy = xdy * rec;
  assign dgx = cubic_r ? pqx[SH3 +: 8] : pqx[SH2 +: 8];
  assign dgy = cubic_r ? pqy[SH3 +: 8] : pqy[SH2 +: 8];

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign vtx_push = (state_r == S_EMIT) && !oq_full;
  // quotients are offset by 2^31; flip the sign bit back
  assign vtx.x    = {~qx_r[bpf_pkg::CW-1], qx_r[bpf_pkg::CW-2:0]};
  assign vtx.y    = {~qy_r[bpf_pkg::CW-1], qy_r[bpf_pkg::CW-2:0]};
  assign vtx.brk  = brk_r;
  assign vtx.last = last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.func == bpf_pkg::FN_MOVE || cmd.func == bpf_pkg::FN_LINE) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_WGT;
          end
        end
      end
      S_WGT:  state_nxt = S_MUL;
      S_MUL:  if (k_r == 2'd3) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 5'd0) state_nxt = S_EMIT;
      S_EMIT: begin
        if (!oq_full) state_nxt = last_r ? S_IDLE : S_WGT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_x_r <= '0;
      cur_y_r <= '0;
      i_r     <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_x_r <= cmd.ex;
            cur_y_r <= cmd.ey;
            i_r     <= '0;
          end
        end
        S_WGT: k_r <= 2'd0;
        S_MUL: k_r <= k_r + 2'd1;
        // four bytes, each looked up, then reduced
        S_SUM: cnt_r <= 5'd7;
        S_DIV: cnt_r <= cnt_r - 5'd1;
        S_EMIT: begin
          if (!oq_full && !last_r) i_r <= i_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          px_r[0] <= cur_x_r;
          py_r[0] <= cur_y_r;
          px_r[1] <= cmd.p1x;
          py_r[1] <= cmd.p1y;
          px_r[2] <= cmd.p2x;
          py_r[2] <= cmd.p2y;
          px_r[3] <= cmd.p3x;
          py_r[3] <= cmd.p3y;
          cubic_r <= (cmd.func == bpf_pkg::FN_CUBIC);
          brk_r   <= (cmd.func == bpf_pkg::FN_MOVE);
          last_r  <= 1'b1;
          qx_r    <= {~cmd.ex[bpf_pkg::CW-1], cmd.ex[bpf_pkg::CW-2:0]};
          qy_r    <= {~cmd.ey[bpf_pkg::CW-1], cmd.ey[bpf_pkg::CW-2:0]};
        end
      end
      S_WGT: begin
        for (int n = 0; n < 4; n++) w_r[n] <= w_nxt[n];
      end
      S_MUL: begin
        prx_r <= AW'(mx);
        pry_r <= AW'(my);
        acx_r <= (k_r == 2'd0) ? '0 : sx;
        acy_r <= (k_r == 2'd0) ? '0 : sy;
      end
      S_SUM: begin
        // the part above bit 31 is already below the divisor
        rx_r   <= nvx[bpf_pkg::CW +: RB];
        ry_r   <= nvy[bpf_pkg::CW +: RB];
        lx_r   <= nvx[bpf_pkg::CW-1:0];
        ly_r   <= nvy[bpf_pkg::CW-1:0];
        brk_r  <= 1'b0;
        last_r <= is_seg;
      end
      S_DIV: begin
        if (cnt_r[0]) begin
          xx_r <= xdx;
          xy_r <= xdy;
          dx_r <= dgx;
          dy_r <= dgy;
          lx_r <= {lx_r[bpf_pkg::CW-9:0], 8'd0};
          ly_r <= {ly_r[bpf_pkg::CW-9:0], 8'd0};
        end else begin
          rx_r <= RB'(xx_r - dx_r * mdv);
          ry_r <= RB'(xy_r - dy_r * mdv);
          qx_r <= {qx_r[bpf_pkg::CW-9:0], dx_r};
          qy_r <= {qy_r[bpf_pkg::CW-9:0], dy_r};
        end
      end
      default: begin
      end
    endcase
  end

  a_pen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_take |=> $stable(cur_x_r) && $stable(cur_y_r))
    else $error("pen moved without a command");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == 5'd0) |=> (state_r == S_EMIT))
    else $error("divider did not hand over after last byte");

  a_mac_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) && (k_r == 2'd3) |=> (state_r == S_SUM) && (k_r == 2'd0))
    else $error("accumulate did not finish after four terms");

endmodule

>>> design/bpf_outq.sv
// bpf_outq: two-word vertex queue between the evaluator and the result port.
// Depends on bpf_pkg.
`timescale 1ns / 1ps
module bpf_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  bpf_pkg::vtx_t wdata,
  output logic          oq_full,
  output logic          empty,
  input  logic          pop,
  output bpf_pkg::vtx_t rdata
);

  bpf_pkg::vtx_t q_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          wr_en, rd_en;

  assign oq_full = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = q_r[rd_ptr_r];
  assign wr_en   = wr && !oq_full;
  assign rd_en   = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

>>> design/bezier_path_flattener_core.sv
// Path flattener: each pushed command (move, line, quadratic, cubic) yields vertices in
// Q16.16. A move or line gives one vertex, emitted without the weight, multiply or divide steps.
// A curve gives SEGMENTS+1 vertices; each one takes a weight step, four terms through the
// shared multiply-accumulate, a step to form the rounded dividend, the divider (four
// quotient bytes by reciprocal multiply, each looked up, then reduced) and an emit step
// that waits while the vertex queue is full. Two-word queues on both sides let commands
// be pushed and vertices popped independently of the evaluator.
// Depends on bpf_pkg, bpf_front, bpf_eval and bpf_outq.
`timescale 1ns / 1ps
module bezier_path_flattener_core #(
  parameter int SEGMENTS = bpf_pkg::SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_func,
  input  logic signed [bpf_pkg::CW-1:0] in_ax,
  input  logic signed [bpf_pkg::CW-1:0] in_ay,
  input  logic signed [bpf_pkg::CW-1:0] in_bx,
  input  logic signed [bpf_pkg::CW-1:0] in_by,
  input  logic signed [bpf_pkg::CW-1:0] in_cx,
  input  logic signed [bpf_pkg::CW-1:0] in_cy,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [bpf_pkg::CW-1:0] out_vertex_x,
  output logic signed [bpf_pkg::CW-1:0] out_vertex_y,
  output logic                          out_breaks_path,
  output logic                          out_last
);

  logic          cmd_valid, cmd_take, vtx_push, oq_full;
  bpf_pkg::cmd_t cmd;
  bpf_pkg::vtx_t vtx, head;

  bpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_func   (in_func),
    .in_ax     (in_ax),
    .in_ay     (in_ay),
    .in_bx     (in_bx),
    .in_by     (in_by),
    .in_cx     (in_cx),
    .in_cy     (in_cy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  bpf_eval #(
    .SEGMENTS (SEGMENTS)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .vtx_push  (vtx_push),
    .vtx       (vtx),
    .oq_full   (oq_full)
  );

  bpf_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (vtx_push),
    .wdata   (vtx),
    .oq_full (oq_full),
    .empty   (empty),
    .pop     (pop),
    .rdata   (head)
  );

  assign out_vertex_x    = head.x;
  assign out_vertex_y    = head.y;
  assign out_breaks_path = head.brk;
  assign out_last        = head.last;

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking testbench of bezier_path_flattener_core.
// Drives path commands, predicts the flattened vertices in place and checks
// every popped word against them. Depends on bpf_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int NSEG = bpf_pkg::SEGMENTS_DEF;
  localparam int N_RAND = 366;
  localparam int N_CALM = 40;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 2500;

  typedef struct {
    bpf_pkg::func_t          f;
    logic [bpf_pkg::CW-1:0]  ax, ay, bx, by, cx, cy;
    bit                      typed;
    logic [bpf_pkg::CW-1:0]  ex, ey;
    bit                      eb;
  } cmd_row_t;

  localparam logic [bpf_pkg::CW-1:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [bpf_pkg::CW-1:0] NMIN = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] in_func = '0;
  logic signed [bpf_pkg::CW-1:0] in_ax = '0, in_ay = '0, in_bx = '0, in_by = '0;
  logic signed [bpf_pkg::CW-1:0] in_cx = '0, in_cy = '0;
  logic full, empty, out_breaks_path, out_last;
  logic signed [bpf_pkg::CW-1:0] out_vertex_x, out_vertex_y;

  bpf_pkg::vtx_t vertex_q[$];
  longint pen_x, pen_y;
  int errors = 0;
  longint cycles = 0;
  bit word_taken = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  cmd_row_t dir_tab[14] = '{
    '{bpf_pkg::FN_CUBIC, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_MOVE, PMAX, PMAX, 32'h1234_5678, NMIN, 32'hDEAD_BEEF, 32'h1,
      1'b1, PMAX, PMAX, 1'b1},
    '{bpf_pkg::FN_LINE, NMIN, NMIN, PMAX, PMAX, PMAX, PMAX, 1'b1, NMIN, NMIN, 1'b0},
    '{bpf_pkg::FN_QUAD, PMAX, PMAX, NMIN, NMIN, '0, '0, 1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_CUBIC, NMIN, NMIN, PMAX, PMAX, PMAX, PMAX, 1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_MOVE, '0, '0, PMAX, PMAX, NMIN, NMIN, 1'b1, '0, '0, 1'b1},
    '{bpf_pkg::FN_LINE, 32'hFFFF_FFFF, 32'h1, '0, '0, '0, '0,
      1'b1, 32'hFFFF_FFFF, 32'h1, 1'b0},
    '{bpf_pkg::FN_QUAD, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, PMAX, NMIN,
      1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_CUBIC, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_LINE, 32'h0001_0000, 32'hFFFF_0000, '0, '0, '0, '0,
      1'b1, 32'h0001_0000, 32'hFFFF_0000, 1'b0},
    '{bpf_pkg::FN_CUBIC, PMAX, NMIN, NMIN, PMAX, PMAX, NMIN, 1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_QUAD, PMAX, NMIN, PMAX, NMIN, '0, '0, 1'b0, '0, '0, 1'b0},
    '{bpf_pkg::FN_MOVE, NMIN, PMAX, '0, '0, '0, '0, 1'b1, NMIN, PMAX, 1'b1},
    '{bpf_pkg::FN_CUBIC, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, 1'b0, '0, '0, 1'b0}
  };

  bezier_path_flattener_core DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_func(in_func), .in_ax(in_ax), .in_ay(in_ay), .in_bx(in_bx), .in_by(in_by),
    .in_cx(in_cx), .in_cy(in_cy), .empty(empty), .pop(pop),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_breaks_path(out_breaks_path), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // nearest, ties toward plus infinity
  function automatic logic [bpf_pkg::CW-1:0] round_q(longint num, longint den);
    longint n, d, q;
    n = 2 * num + den;
    d = 2 * den;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q[bpf_pkg::CW-1:0];
  endfunction

  // queue the vertices one command yields and move the pen
  task automatic flatten_cmd(bpf_pkg::func_t f,
                             logic signed [bpf_pkg::CW-1:0] ax, ay, bx, by, cx, cy);
    longint t, u, w0, w1, w2, w3, nx, ny, den;
    bpf_pkg::vtx_t v;
    if (f == bpf_pkg::FN_MOVE || f == bpf_pkg::FN_LINE) begin
      v = '{x: ax, y: ay, brk: (f == bpf_pkg::FN_MOVE), last: 1'b1};
      vertex_q.push_back(v);
      pen_x = ax;
      pen_y = ay;
    end else begin
      for (int i = 0; i <= NSEG; i++) begin
        t = i;
        u = NSEG - i;
        if (f == bpf_pkg::FN_QUAD) begin
          w0 = u * u; w1 = 2 * t * u; w2 = t * t; w3 = 0;
          den = longint'(NSEG) * NSEG;
        end else begin
          w0 = u * u * u; w1 = 3 * t * u * u; w2 = 3 * t * t * u; w3 = t * t * t;
          den = longint'(NSEG) * NSEG * NSEG;
        end
        nx = w0 * pen_x + w1 * longint'(ax) + w2 * longint'(bx) + w3 * longint'(cx);
        ny = w0 * pen_y + w1 * longint'(ay) + w2 * longint'(by) + w3 * longint'(cy);
        v = '{x: round_q(nx, den), y: round_q(ny, den), brk: 1'b0, last: (i == NSEG)};
        vertex_q.push_back(v);
      end
      pen_x = (f == bpf_pkg::FN_QUAD) ? longint'(bx) : longint'(cx);
      pen_y = (f == bpf_pkg::FN_QUAD) ? longint'(by) : longint'(cy);
    end
  endtask

  // accept and check on the rising edge
  always @(posedge clk) begin
    bpf_pkg::vtx_t e;
    cycles <= cycles + 1;
    word_taken = rst_n && push && !full;
    if (word_taken) begin
      flatten_cmd(bpf_pkg::func_t'(in_func), in_ax, in_ay, in_bx, in_by, in_cx, in_cy);
    end
    if (rst_n && pop && !empty) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex x=%h y=%h", out_vertex_x, out_vertex_y);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (out_vertex_x !== e.x) begin
          $error("vertex_x exp %h got %h", e.x, out_vertex_x); errors++;
        end
        if (out_vertex_y !== e.y) begin
          $error("vertex_y exp %h got %h", e.y, out_vertex_y); errors++;
        end
        if (out_breaks_path !== e.brk) begin
          $error("breaks_path exp %b got %b", e.brk, out_breaks_path); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %b got %b", e.last, out_last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[bezier_path_flattener_core] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop = 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // hold the command on the port until a rising edge takes it
  task automatic send_cmd(bpf_pkg::func_t f, logic [bpf_pkg::CW-1:0] ax, ay, bx, by, cx, cy);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_func = f;
    in_ax = ax; in_ay = ay; in_bx = bx; in_by = by; in_cx = cx; in_cy = cy;
    push = 1'b1;
    do @(negedge clk); while (!word_taken);
  endtask

  function automatic logic [bpf_pkg::CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return PMAX;
      1: return NMIN;
      2, 3: return $unsigned($signed($urandom_range(0, 400)) - 200) << 16;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    bpf_pkg::func_t f;
    bpf_pkg::vtx_t v;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_tab[k]) begin
      send_cmd(dir_tab[k].f, dir_tab[k].ax, dir_tab[k].ay, dir_tab[k].bx, dir_tab[k].by,
               dir_tab[k].cx, dir_tab[k].cy);
      // replace the predicted single vertex by the one read off the table
      if (dir_tab[k].typed) begin
        v = '{x: dir_tab[k].ex, y: dir_tab[k].ey, brk: dir_tab[k].eb, last: 1'b1};
        vertex_q[vertex_q.size() - 1] = v;
      end
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 60) hold_req = 1'b1;
      if (n == 200) begin
        push = 1'b0;
        do @(negedge clk); while (vertex_q.size() != 0);
      end
      if (n == N_RAND - N_CALM) calm = 1'b1;
      // keep curves at about 40 percent
      case ($urandom_range(0, 9))
        0, 1, 2: f = bpf_pkg::FN_MOVE;
        3, 4, 5: f = bpf_pkg::FN_LINE;
        6, 7: f = bpf_pkg::FN_QUAD;
        default: f = bpf_pkg::FN_CUBIC;
      endcase
      send_cmd(f, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord());
    end
    push = 1'b0;
    do @(negedge clk); while (vertex_q.size() != 0);
    repeat (200) @(negedge clk);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("[bezier_path_flattener_core] OK");
    end else begin
      $display("[bezier_path_flattener_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/bpf_pkg.sv
design/bpf_front.sv
design/bpf_eval.sv
design/bpf_outq.sv
design/bezier_path_flattener_core.sv
verif/tb_top.sv
